FILE: rtl/ivp_pkg.sv
package ivp_pkg;

    localparam logic [1:0] KIND_RAISE = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_EOI   = 2'd2;

    localparam logic CFG_TASK_PRIORITY      = 1'b0;
    localparam logic CFG_CONTROLLER_ENABLED = 1'b1;

    localparam int CFG_W  = 8;
    localparam int WORD_W = 32;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] vector;
        logic       level_triggered;
    } t_in_item;

    typedef struct packed {
        logic       newly_set;
        logic       eoi_done;
        logic [7:0] eoi_vector;
        logic       eoi_level;
        logic       pending_valid;
        logic [7:0] pending_vector;
        logic [7:0] processor_priority;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_start;
        logic scan;
        logic retire;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic is_eoi;
        logic out_ready;
    } t_status;

    // highest set bit of a 32-bit word
    function automatic logic [4:0] top_bit(input logic [WORD_W-1:0] w);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < WORD_W; i++) begin
            if (w[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/ivp_ctrl.sv
module ivp_ctrl #(
    parameter int VECTOR_COUNT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ivp_pkg::t_status     i_status,
    output ivp_pkg::t_cmd        o_cmd,
    output logic [((((VECTOR_COUNT + 31) / 32) > 1) ?
                   $clog2((VECTOR_COUNT + 31) / 32) : 1) - 1:0] o_widx
);

    localparam int WORDS  = (VECTOR_COUNT + 31) / 32;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_APPLY  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RETIRE = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [WIDX_W-1:0] r_widx, n_widx;
    logic              r_eoi_phase, n_eoi_phase;

    always_comb begin
        n_state     = r_state;
        n_widx      = r_widx;
        n_eoi_phase = r_eoi_phase;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply      = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_widx           = WIDX_W'(WORDS - 1);
                n_eoi_phase      = i_status.is_eoi;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_widx == '0) begin
                    n_state = r_eoi_phase ? S_RETIRE : S_RESULT;
                end else begin
                    n_widx = r_widx - 1'b1;
                end
            end
            S_RETIRE: begin
                o_cmd.retire     = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_widx           = WIDX_W'(WORDS - 1);
                n_eoi_phase      = 1'b0;
                n_state          = S_SCAN;
            end
            S_RESULT: begin
                o_cmd.result = 1'b1;
                if (i_status.out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_eoi_phase <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_widx      <= n_widx;
            r_eoi_phase <= n_eoi_phase;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_widx     = r_widx;

`ifndef NO_ASSERTIONS
    a_scan_runs_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (r_widx != '0) |=> (r_state == S_SCAN))
        else $error("scan left before word zero");

    a_retire_only_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RETIRE) |=> !r_eoi_phase)
        else $error("second retire phase pending");
`endif

endmodule

FILE: rtl/ivp_dp.sv
module ivp_dp #(
    parameter int VECTOR_COUNT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ivp_pkg::t_cmd         i_cmd,
    output ivp_pkg::t_status      o_status,
    input  logic [((((VECTOR_COUNT + 31) / 32) > 1) ?
                   $clog2((VECTOR_COUNT + 31) / 32) : 1) - 1:0] i_widx,
    input  ivp_pkg::t_in_item     i_in_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [ivp_pkg::CFG_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ivp_pkg::t_out_item    o_out_data
);

    localparam int WORDS = (VECTOR_COUNT + 31) / 32;
    localparam int NBITS = WORDS * ivp_pkg::WORD_W;
    localparam int BIT_W = $clog2(NBITS);

    logic [NBITS-1:0]  r_irr, r_isr, r_tmr;
    logic [7:0]        r_tpr;
    logic              r_en;
    ivp_pkg::t_in_item r_item;
    logic              r_newly;
    logic              r_eoi_done, r_eoi_level;
    logic [7:0]        r_eoi_vec;
    logic              r_irr_found, r_isr_found;
    logic [7:0]        r_irr_vec, r_isr_vec;
    logic              r_out_valid;
    ivp_pkg::t_out_item r_out, n_out;

    logic [ivp_pkg::WORD_W-1:0] irr_word, isr_word;
    logic [BIT_W-1:0]  item_idx, isr_idx;
    logic              in_range;
    logic              out_ready;
    logic [7:0]        isrv;

    assign irr_word  = r_irr[{i_widx, 5'd0} +: ivp_pkg::WORD_W];
    assign isr_word  = r_isr[{i_widx, 5'd0} +: ivp_pkg::WORD_W];
    assign item_idx  = r_item.vector[BIT_W-1:0];
    assign isr_idx   = r_isr_vec[BIT_W-1:0];
    assign in_range  = ({1'b0, r_item.vector} < 9'(VECTOR_COUNT));
    assign out_ready = !r_out_valid || !i_out_stall;

    assign o_status.is_eoi    = (r_item.kind == ivp_pkg::KIND_EOI);
    assign o_status.out_ready = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpr <= '0;
            r_en  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ivp_pkg::CFG_TASK_PRIORITY:      r_tpr <= i_cfg_data;
                ivp_pkg::CFG_CONTROLLER_ENABLED: r_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irr       <= '0;
            r_isr       <= '0;
            r_tmr       <= '0;
            r_newly     <= 1'b0;
            r_eoi_done  <= 1'b0;
            r_eoi_level <= 1'b0;
            r_eoi_vec   <= '0;
            r_irr_found <= 1'b0;
            r_isr_found <= 1'b0;
            r_irr_vec   <= '0;
            r_isr_vec   <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_newly     <= 1'b0;
                r_eoi_done  <= 1'b0;
                r_eoi_level <= 1'b0;
                r_eoi_vec   <= '0;
            end
            if (i_cmd.apply && in_range) begin
                if (r_item.kind == ivp_pkg::KIND_RAISE) begin
                    r_newly         <= !r_irr[item_idx];
                    r_irr[item_idx] <= 1'b1;
                    if (r_item.level_triggered) begin
                        r_tmr[item_idx] <= 1'b1;
                    end
                end else if (r_item.kind == ivp_pkg::KIND_ACK) begin
                    r_isr[item_idx] <= 1'b1;
                    r_irr[item_idx] <= 1'b0;
                end
            end
            if (i_cmd.retire && r_isr_found) begin
                r_isr[isr_idx] <= 1'b0;
                r_tmr[isr_idx] <= 1'b0;
                r_eoi_level    <= r_tmr[isr_idx];
                r_eoi_done     <= 1'b1;
                r_eoi_vec      <= r_isr_vec;
            end
            if (i_cmd.scan_start) begin
                r_irr_found <= 1'b0;
                r_isr_found <= 1'b0;
                r_irr_vec   <= '0;
                r_isr_vec   <= '0;
            end else if (i_cmd.scan) begin
                // words go from the top down, so the first hit is the highest
                if (!r_irr_found && (irr_word != '0)) begin
                    r_irr_found <= 1'b1;
                    r_irr_vec   <= 8'({i_widx, ivp_pkg::top_bit(irr_word)});
                end
                if (!r_isr_found && (isr_word != '0)) begin
                    r_isr_found <= 1'b1;
                    r_isr_vec   <= 8'({i_widx, ivp_pkg::top_bit(isr_word)});
                end
            end
        end
    end

    always_comb begin
        isrv = r_isr_found ? r_isr_vec : 8'd0;
        n_out = '0;
        n_out.newly_set  = r_newly;
        n_out.eoi_done   = r_eoi_done;
        n_out.eoi_vector = r_eoi_vec;
        n_out.eoi_level  = r_eoi_level;
        if (r_tpr[7:4] >= isrv[7:4]) begin
            n_out.processor_priority = r_tpr;
        end else begin
            n_out.processor_priority = {isrv[7:4], 4'h0};
        end
        if (r_en && r_irr_found && (isrv[7:4] < r_irr_vec[7:4])) begin
            n_out.pending_valid  = 1'b1;
            n_out.pending_vector = r_irr_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result && out_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result && out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_retire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.retire && r_isr_found |=> !r_isr[$past(isr_idx)] && !r_tmr[$past(isr_idx)])
        else $error("retired vector still in service");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.result && out_ready |=> r_out_valid)
        else $error("result transfer lost");

    a_no_pending_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.pending_valid |-> (r_out.pending_vector == 8'd0))
        else $error("pending vector without pending flag");

    a_eoi_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.eoi_done |-> (r_out.eoi_vector == 8'd0) && !r_out.eoi_level)
        else $error("eoi fields set without retire");
`endif

endmodule

FILE: rtl/interrupt_vector_priority_core.sv
// Interrupt vector priority core: request, in-service and trigger-mode bitmaps.
// Input channel (i_in_valid / o_in_stall / i_in_data): one event per transfer,
// kind raise, acknowledge or end of interrupt. Output channel (o_out_valid /
// i_out_stall / o_out_data): exactly one result per event, in order.
// Config port: i_cfg_we, i_cfg_index (0 task priority, 1 enable), i_cfg_data;
// write only while no event is in flight.
// Each bitmap holds W = ceil(VECTOR_COUNT / 32) words. An event is applied and
// scanned once; an end of interrupt is then retired and scanned again (one scan
// to find the retired vector, one scan for the new status). Each scan is
// word-serial: one 32-bit word of both the request and in-service maps is
// priority encoded per cycle, top word first. o_in_stall holds off new events
// until the result of the current one has been loaded into the output register.
// A new event is taken while the previous result still waits in the output
// register; a stalled receiver holds the result and, once the next result is
// ready, holds the block in its result state.
// Reset (synchronous, i_rst_n low) clears all bitmaps, both config registers
// and the output valid.
module interrupt_vector_priority_core #(
    parameter int VECTOR_COUNT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  ivp_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output ivp_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [ivp_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int WORDS  = (VECTOR_COUNT + 31) / 32;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    ivp_pkg::t_cmd     cmd;
    ivp_pkg::t_status  status;
    logic [WIDX_W-1:0] widx;

    ivp_ctrl #(
        .VECTOR_COUNT(VECTOR_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_widx     (widx)
    );

    ivp_dp #(
        .VECTOR_COUNT(VECTOR_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_widx      (widx),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: tb/sv/interrupt_vector_priority_core_tb.sv
module interrupt_vector_priority_core_tb;

    localparam int VEC_COUNT = 256;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_EVENTS = 280;
    localparam int SETTLE_CYCLES = 25;
    localparam int REPORT_MAX = 60;
    localparam ivp_pkg::t_out_item NO_STATUS = '0;
    localparam ivp_pkg::t_out_item NEWLY_ONLY = ivp_pkg::t_out_item'({1'b1, 27'd0});

    typedef struct {
        logic              cfg;
        logic [7:0]        tp;
        logic              en;
        ivp_pkg::t_in_item ev;
        logic              typed;
        ivp_pkg::t_out_item want;
    } t_dir_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    ivp_pkg::t_in_item         i_in_data = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    ivp_pkg::t_out_item        o_out_data;
    logic                      i_cfg_we = 1'b0;
    logic                      i_cfg_index = 1'b0;
    logic [ivp_pkg::CFG_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [VEC_COUNT-1:0] req_map = '0;
    logic [VEC_COUNT-1:0] isr_map = '0;
    logic [VEC_COUNT-1:0] tmr_map = '0;
    logic [7:0]           tpr_reg = '0;
    logic                 enable_reg = 1'b0;

    ivp_pkg::t_out_item   status_q[$];
    t_dir_row             dir_rows[$];
    int                   errors = 0;
    int                   results_seen = 0;
    int                   in_idle_pct = 27;
    int                   out_idle_pct = 27;
    logic                 hold_go = 1'b0;
    int                   hold_count = 0;

    interrupt_vector_priority_core #(
        .VECTOR_COUNT(VEC_COUNT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int top_of(input logic [VEC_COUNT-1:0] m);
        for (int i = VEC_COUNT - 1; i >= 0; i--) begin
            if (m[i]) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic ivp_pkg::t_out_item apply_event(input ivp_pkg::t_in_item it);
        ivp_pkg::t_out_item r;
        int        isr_top;
        int        irr_top;
        logic [7:0] isr_v;
        logic [7:0] irr_v;
        r = '0;
        case (it.kind)
            ivp_pkg::KIND_RAISE: begin
                r.newly_set = !req_map[it.vector];
                req_map[it.vector] = 1'b1;
                if (it.level_triggered) begin
                    tmr_map[it.vector] = 1'b1;
                end
            end
            ivp_pkg::KIND_ACK: begin
                isr_map[it.vector] = 1'b1;
                req_map[it.vector] = 1'b0;
            end
            ivp_pkg::KIND_EOI: begin
                isr_top = top_of(isr_map);
                if (isr_top >= 0) begin
                    isr_map[isr_top] = 1'b0;
                    r.eoi_level = tmr_map[isr_top];
                    tmr_map[isr_top] = 1'b0;
                    r.eoi_done = 1'b1;
                    r.eoi_vector = 8'(isr_top);
                end
            end
            default: begin
            end
        endcase
        isr_top = top_of(isr_map);
        isr_v = (isr_top >= 0) ? 8'(isr_top) : 8'd0;
        if ((tpr_reg & 8'hf0) >= (isr_v & 8'hf0)) begin
            r.processor_priority = tpr_reg;
        end else begin
            r.processor_priority = isr_v & 8'hf0;
        end
        irr_top = top_of(req_map);
        if (enable_reg && irr_top >= 0) begin
            irr_v = 8'(irr_top);
            if ((isr_v & 8'hf0) < (irr_v & 8'hf0)) begin
                r.pending_valid = 1'b1;
                r.pending_vector = irr_v;
            end
        end
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic cfg, input logic [7:0] tp, input logic en,
                                        input logic [1:0] kind, input logic [7:0] vec,
                                        input logic lvl, input logic typed,
                                        input ivp_pkg::t_out_item want);
        t_dir_row row;
        row.cfg = cfg;
        row.tp = tp;
        row.en = en;
        row.ev.kind = kind;
        row.ev.vector = vec;
        row.ev.level_triggered = lvl;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    // mostly well-formed traffic: raise, acknowledge the top request, retire
    function automatic ivp_pkg::t_in_item next_event();
        ivp_pkg::t_in_item it;
        int       pick;
        int       top;
        it.kind = ivp_pkg::KIND_RAISE;
        it.vector = 8'($urandom);
        it.level_triggered = 1'($urandom);
        pick = $urandom_range(99);
        top = top_of(req_map);
        if (pick < 40) begin
            if ($urandom_range(3) == 0 && top >= 0) begin
                it.vector = 8'(top);
            end
        end else if (pick < 68) begin
            it.kind = ivp_pkg::KIND_ACK;
            if (top >= 0 && $urandom_range(9) < 8) begin
                it.vector = 8'(top);
            end
        end else if (pick < 95) begin
            it.kind = ivp_pkg::KIND_EOI;
        end else begin
            it.kind = KIND_UNKNOWN;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got,
                     want);
        end
    endtask

    task automatic send_event(input ivp_pkg::t_in_item it, input logic typed,
                              input ivp_pkg::t_out_item want);
        ivp_pkg::t_out_item pred;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pred = apply_event(it);
        status_q.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] tp, input logic en);
        i_cfg_we <= 1'b1;
        i_cfg_index <= ivp_pkg::CFG_TASK_PRIORITY;
        i_cfg_data <= tp;
        @(posedge i_clk);
        i_cfg_index <= ivp_pkg::CFG_CONTROLLER_ENABLED;
        i_cfg_data <= {{(ivp_pkg::CFG_W-1){1'b0}}, en};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tpr_reg = tp;
        enable_reg = en;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_go && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        ivp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (status_q.size() == 0) begin
                report_mismatch("transfer with nothing expected", int'(o_out_data), 0);
            end else begin
                want = status_q.pop_front();
                if (o_out_data.newly_set !== want.newly_set)
                    report_mismatch("newly_set", o_out_data.newly_set, want.newly_set);
                if (o_out_data.eoi_done !== want.eoi_done)
                    report_mismatch("eoi_done", o_out_data.eoi_done, want.eoi_done);
                if (o_out_data.eoi_vector !== want.eoi_vector)
                    report_mismatch("eoi_vector", o_out_data.eoi_vector, want.eoi_vector);
                if (o_out_data.eoi_level !== want.eoi_level)
                    report_mismatch("eoi_level", o_out_data.eoi_level, want.eoi_level);
                if (o_out_data.pending_valid !== want.pending_valid)
                    report_mismatch("pending_valid", o_out_data.pending_valid,
                                    want.pending_valid);
                if (o_out_data.pending_vector !== want.pending_vector)
                    report_mismatch("pending_vector", o_out_data.pending_vector,
                                    want.pending_vector);
                if (o_out_data.processor_priority !== want.processor_priority)
                    report_mismatch("processor_priority", o_out_data.processor_priority,
                                    want.processor_priority);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("interrupt_vector_priority_core regression: fail");
        $finish;
    end

    initial begin
        logic [7:0] tp;
        logic       en;
        // reset config: disabled, task priority 0
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, ivp_pkg::KIND_RAISE, 8'hff, 1'b1, 1'b1,
                                  NEWLY_ONLY));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, ivp_pkg::KIND_RAISE, 8'hff, 1'b0, 1'b1,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, KIND_UNKNOWN, 8'ha5, 1'b1, 1'b1,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, ivp_pkg::KIND_EOI, 8'h00, 1'b0, 1'b1,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, ivp_pkg::KIND_RAISE, 8'h00, 1'b0, 1'b1,
                                  NEWLY_ONLY));
        // enabled, lowest task priority
        dir_rows.push_back(mk_row(1'b1, 8'h00, 1'b1, ivp_pkg::KIND_RAISE, 8'h10, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, ivp_pkg::KIND_ACK, 8'hff, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, ivp_pkg::KIND_ACK, 8'h80, 1'b1, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, ivp_pkg::KIND_EOI, 8'h33, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, ivp_pkg::KIND_EOI, 8'h00, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, ivp_pkg::KIND_ACK, 8'h00, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, ivp_pkg::KIND_EOI, 8'h00, 1'b0, 1'b0,
                                  NO_STATUS));
        // highest task priority
        dir_rows.push_back(mk_row(1'b1, 8'hff, 1'b1, ivp_pkg::KIND_RAISE, 8'h7f, 1'b1, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'hff, 1'b1, ivp_pkg::KIND_ACK, 8'h10, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'hff, 1'b1, ivp_pkg::KIND_EOI, 8'h00, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'hff, 1'b1, KIND_UNKNOWN, 8'hff, 1'b0, 1'b0,
                                  NO_STATUS));
        // disabled again, mid task priority
        dir_rows.push_back(mk_row(1'b1, 8'h5c, 1'b0, ivp_pkg::KIND_RAISE, 8'h55, 1'b1, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h5c, 1'b0, ivp_pkg::KIND_ACK, 8'h7f, 1'b1, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h5c, 1'b0, ivp_pkg::KIND_EOI, 8'h00, 1'b0, 1'b0,
                                  NO_STATUS));
        dir_rows.push_back(mk_row(1'b0, 8'h5c, 1'b0, ivp_pkg::KIND_EOI, 8'h00, 1'b0, 1'b0,
                                  NO_STATUS));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                drain();
                write_config(dir_rows[i].tp, dir_rows[i].en);
            end
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            tp = 8'($urandom);
            en = 1'b1;
            case (phase)
                0: tp = 8'h00;
                1: tp = 8'hff;
                3: en = 1'b0;
                4: tp = 8'hf0;
                default: begin
                end
            endcase
            write_config(tp, en);
            in_idle_pct = (phase == 2) ? 0 : 27;
            out_idle_pct = (phase == 2) ? 0 : 27;
            if (phase == 1) begin
                hold_go = 1'b1;
            end
            repeat (PHASE_EVENTS) send_event(next_event(), 1'b0, NO_STATUS);
        end

        drain();
        if (errors == 0) begin
            $display("interrupt_vector_priority_core regression: pass");
        end else begin
            $display("interrupt_vector_priority_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/ivp_pkg.sv
rtl/ivp_ctrl.sv
rtl/ivp_dp.sv
rtl/interrupt_vector_priority_core.sv
tb/sv/interrupt_vector_priority_core_tb.sv
